// ----- hw/rtl/wall_follow_pid_drive_assert.svh -----
// Assertion macros for the wall-follow drive RTL.
// Depends on nothing; included by wfpd_ctrl, which carries concurrent checks.
`ifndef WALL_FOLLOW_PID_DRIVE_ASSERT_SVH
`define WALL_FOLLOW_PID_DRIVE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WFPD_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("wfpd check failed");

// Next-cycle implication, checked outside reset.
`define WFPD_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wfpd check failed");

`endif

// ----- hw/rtl/wfpd_pkg.sv -----
// Package for the wall-follow PID drive: payload structs, register set, codes and helpers.
// Depends on nothing; used by every module of the block.
package wfpd_pkg;

   localparam int RANGE_MAX_CM = 100;
   localparam int FRAC_BITS    = 4;
   localparam int GAIN_FRAC    = 4;

   localparam int CM_W   = 7;
   localparam int AVG_W  = CM_W + FRAC_BITS;
   localparam int EP_W   = 14;
   localparam int ED_W   = EP_W + 1;
   localparam int INT_W  = 16;
   localparam int ACC_W  = 27;
   localparam int ERR_W  = 12;
   localparam int DRV_W  = 14;
   localparam int SUM_SHIFT = FRAC_BITS + GAIN_FRAC;

   // Division by three: floor(n * ceil(2^17 / 3) / 2^17) is exact for n below 2^17.
   localparam int DIV3_SHIFT = 17;
   localparam int DIV3_IN_W  = INT_W + 1;
   localparam logic [DIV3_IN_W-1:0] DIV3_RECIP = DIV3_IN_W'(((1 << DIV3_SHIFT) + 2) / 3);
   localparam int Q3_W = INT_W - 1;

   localparam logic [AVG_W:0] MAX_AVG = (AVG_W + 1)'(RANGE_MAX_CM << FRAC_BITS);

   localparam logic [2:0] HEAD_STOP    = 3'd0;
   localparam logic [2:0] HEAD_FORWARD = 3'd1;
   localparam logic [2:0] HEAD_LEFT    = 3'd3;
   localparam logic [2:0] HEAD_RIGHT   = 3'd4;

   localparam logic [1:0] MODE_CENTER = 2'd0;
   localparam logic [1:0] MODE_LEFT   = 2'd1;
   localparam logic [1:0] MODE_RIGHT  = 2'd2;

   localparam int ADDR_W = 5;
   localparam logic [2:0] REG_GAIN_P      = 3'd0;
   localparam logic [2:0] REG_GAIN_I      = 3'd1;
   localparam logic [2:0] REG_GAIN_D      = 3'd2;
   localparam logic [2:0] REG_SIDE_OFFSET = 3'd3;
   localparam logic [2:0] REG_BASE_SPEED  = 3'd4;
   localparam logic [2:0] REG_SIDE_LIMIT  = 3'd5;
   localparam logic [2:0] REG_FRONT_LIMIT = 3'd6;

   typedef struct packed {
      logic [CM_W-1:0] left_cm;
      logic [CM_W-1:0] right_cm;
      logic [CM_W-1:0] front_cm;
   } req_type;

   typedef struct packed {
      logic [7:0]              left_drive;
      logic [7:0]              right_drive;
      logic [2:0]              heading;
      logic                    left_wall;
      logic                    right_wall;
      logic                    front_wall;
      logic [1:0]              mode_now;
      logic signed [ERR_W-1:0] control_error;
   } rsp_type;

   typedef struct packed {
      logic [7:0] gain_p;
      logic [7:0] gain_i;
      logic [7:0] gain_d;
      logic [5:0] side_offset;
      logic [7:0] base_speed;
      logic [7:0] side_wall_limit;
      logic [7:0] front_wall_limit;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic err;
      logic integ;
      logic muld;
      logic muli;
      logic fin;
      logic emit;
      logic pass;
   } cmd_type;

   typedef struct packed {
      logic corner;
      logic out_free;
   } sts_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERR,
      ST_INT,
      ST_MULD,
      ST_MULI,
      ST_FIN,
      ST_EMIT
   } ctrl_state_type;

   // Clamp a signed drive value into an 8-bit PWM level.
   function automatic logic [7:0] sat8(input logic signed [DRV_W-1:0] v);
      logic [7:0] r;
      if (v < 0) begin
         r = 8'd0;
      end else if (v > 255) begin
         r = 8'd255;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/wall_follow_pid_drive.sv -----
// Wall-following PID drive controller for a two-wheel robot, top level.
// Depends on wfpd_pkg, wfpd_csr, wfpd_ctrl and wfpd_dp.
//
// Each transfer on the req_ channel carries one set of left, right and front sonar
// distances in centimeters, and exactly one result leaves on the rsp_ channel for it:
// the two motor PWM levels, a heading code, the three wall flags, the follow mode
// after this reading and the control error of the last PID update. The block handles
// one reading at a time. A reading passes through one PID update from its transfer
// until its result is loaded into the output register, or through two at a corner,
// where a second PID update runs. The load waits while the output register still
// holds an untaken result; the next reading can be transferred in once the sequencer
// is back in idle. Each PID update runs these steps in order: the error together
// with the two-thirds integral decay, the integral together with the proportional
// product, the derivative product, the integral product and the final scaling and
// motor mix, followed by the load of the output register. The output register holds a
// finished result while the next reading is transferred in, so a slow consumer costs
// nothing until a second result is ready. Gains, offsets, speed and wall limits are
// written over the csr_ port at byte address four times the register number, by the
// user only while no reading is in flight; the block itself does not enforce this.
module wall_follow_pid_drive (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  wfpd_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output wfpd_pkg::rsp_type         rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [wfpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import wfpd_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // Configuration registers; the datapath reads them directly.
   wfpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The sequencer accepts a reading only when idle and issues one command per cycle, except while waiting at emit.
   wfpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath keeps the averages, PID state, follow mode and the output register.
   wfpd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- hw/rtl/wfpd_csr.sv -----
// Register bank of the wall-follow PID drive, written and read over an APB-style port.
// Depends on wfpd_pkg.
module wfpd_csr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [wfpd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready,
   output wfpd_pkg::cfg_type         cfg
);
   import wfpd_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_GAIN_P:      cfg_in.gain_p           = csr_pwdata[7:0];
            REG_GAIN_I:      cfg_in.gain_i           = csr_pwdata[7:0];
            REG_GAIN_D:      cfg_in.gain_d           = csr_pwdata[7:0];
            REG_SIDE_OFFSET: cfg_in.side_offset      = csr_pwdata[5:0];
            REG_BASE_SPEED:  cfg_in.base_speed       = csr_pwdata[7:0];
            REG_SIDE_LIMIT:  cfg_in.side_wall_limit  = csr_pwdata[7:0];
            REG_FRONT_LIMIT: cfg_in.front_wall_limit = csr_pwdata[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_GAIN_P:      csr_prdata = {24'd0, cfg_ff.gain_p};
         REG_GAIN_I:      csr_prdata = {24'd0, cfg_ff.gain_i};
         REG_GAIN_D:      csr_prdata = {24'd0, cfg_ff.gain_d};
         REG_SIDE_OFFSET: csr_prdata = {26'd0, cfg_ff.side_offset};
         REG_BASE_SPEED:  csr_prdata = {24'd0, cfg_ff.base_speed};
         REG_SIDE_LIMIT:  csr_prdata = {24'd0, cfg_ff.side_wall_limit};
         REG_FRONT_LIMIT: csr_prdata = {24'd0, cfg_ff.front_wall_limit};
         default:         csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= 8'd11;
         cfg_ff.gain_i           <= 8'd6;
         cfg_ff.gain_d           <= 8'd8;
         cfg_ff.side_offset      <= 6'd5;
         cfg_ff.base_speed       <= 8'd10;
         cfg_ff.side_wall_limit  <= 8'd13;
         cfg_ff.front_wall_limit <= 8'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hw/rtl/wfpd_ctrl.sv -----
// Sequencer of the wall-follow PID drive: walks each item through the PID steps.
// Depends on wfpd_pkg and the assertion macro header.
`include "wall_follow_pid_drive_assert.svh"

module wfpd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wfpd_pkg::sts_type sts,
   output wfpd_pkg::cmd_type cmd
);
   import wfpd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           pass_ff, pass_in;

   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ERR;
               pass_in  = 1'b0;
            end
         end
         ST_ERR:  state_in = ST_INT;
         ST_INT:  state_in = ST_MULD;
         ST_MULD: state_in = ST_MULI;
         ST_MULI: state_in = ST_FIN;
         ST_FIN: begin
            if (!pass_ff && sts.corner) begin
               state_in = ST_ERR;
               pass_in  = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      cmd       = '0;
      cmd.pass  = pass_ff;
      case (state_ff)
         ST_IDLE: cmd.load  = req_valid;
         ST_ERR:  cmd.err   = 1'b1;
         ST_INT:  cmd.integ = 1'b1;
         ST_MULD: cmd.muld  = 1'b1;
         ST_MULI: cmd.muli  = 1'b1;
         ST_FIN:  cmd.fin   = 1'b1;
         ST_EMIT: cmd.emit  = sts.out_free;
         default: cmd       = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   `WFPD_ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, state_ff == ST_ERR && !pass_ff)
   `WFPD_ASSERT_NEXT(a_corner_second, clock, reset, state_ff == ST_FIN && !pass_ff && sts.corner, state_ff == ST_ERR && pass_ff)
   `WFPD_ASSERT_NEXT(a_emit_returns, clock, reset, cmd.emit, state_ff == ST_IDLE && req_ready)
   `WFPD_ASSERT_NOW(a_second_needs_corner, clock, reset, state_ff == ST_FIN && pass_ff, sts.corner)

endmodule

// ----- hw/rtl/wfpd_dp.sv -----
// Datapath of the wall-follow PID drive: averages, PID arithmetic, motor mix and result register.
// Depends on wfpd_pkg; driven by commands from wfpd_ctrl.
module wfpd_dp (
   input  logic              clock,
   input  logic              reset,
   input  wfpd_pkg::cfg_type cfg,
   input  wfpd_pkg::cmd_type cmd,
   output wfpd_pkg::sts_type sts,
   input  wfpd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wfpd_pkg::rsp_type rsp_data
);
   import wfpd_pkg::*;

   // Sensor averages and wall flags.
   logic [AVG_W-1:0] lavg_ff, ravg_ff, favg_ff, lavg_in, ravg_in, favg_in;
   logic             lw_ff, rw_ff, fw_ff;
   logic [AVG_W:0]   side_lim, front_lim;

   // PID state and working registers.
   logic signed [EP_W-1:0]  prev_ff, ep_ff, ep_in, off_s, lavg_s, ravg_s;
   logic signed [ED_W-1:0]  ed_ff, ed_in;
   logic signed [INT_W-1:0] integ_ff, integ_in, q_s;
   logic signed [INT_W:0]   two_i, integ_sum;
   logic [DIV3_IN_W-1:0]    mag;
   logic [2*DIV3_IN_W-1:0]  prod3;
   logic [Q3_W-1:0]         q_ff;
   logic                    qneg_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, rounded, shifted;
   logic signed [8:0]       gp_s, gi_s, gd_s;
   logic signed [EP_W+8:0]  prod_p;
   logic signed [ED_W+8:0]  prod_d;
   logic signed [INT_W+8:0] prod_i;
   logic [1:0]              osign;

   // Results of the latest PID update.
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic signed [DRV_W-1:0] base_s, err_w, rms, lms;
   logic [7:0]              ldrv_ff, rdrv_ff, ldrv_in, rdrv_in;
   logic [2:0]              head_ff, head_in;

   logic [1:0] fmode_ff, fmode_in;
   logic       stop;
   logic       corner;
   rsp_type    out_ff, out_in;
   logic       out_valid_ff;

   assign corner   = fw_ff && (lw_ff != rw_ff);
   assign sts.corner   = corner;
   assign sts.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid    = out_valid_ff;
   assign rsp_data     = out_ff;

   // Averaging runs at the input transfer.
   assign lavg_in = AVG_W'(({1'b0, req_data.left_cm, FRAC_BITS'(0)} + {1'b0, lavg_ff}) >> 1);
   assign ravg_in = AVG_W'(({1'b0, req_data.right_cm, FRAC_BITS'(0)} + {1'b0, ravg_ff}) >> 1);
   assign favg_in = AVG_W'(({1'b0, req_data.front_cm, FRAC_BITS'(0)} + {1'b0, favg_ff}) >> 1);
   assign side_lim  = (AVG_W + 1)'({cfg.side_wall_limit, FRAC_BITS'(0)});
   assign front_lim = (AVG_W + 1)'({cfg.front_wall_limit, FRAC_BITS'(0)});

   // Offset sign: 2'b01 add, 2'b10 subtract, 2'b00 none.
   always_comb begin
      if (cmd.pass) begin
         osign = lw_ff ? 2'b01 : 2'b10;
      end else if (fmode_ff == MODE_LEFT) begin
         osign = 2'b10;
      end else if (fmode_ff == MODE_RIGHT) begin
         osign = 2'b01;
      end else begin
         osign = 2'b00;
      end
   end

   assign lavg_s = signed'(EP_W'(lavg_ff));
   assign ravg_s = signed'(EP_W'(ravg_ff));
   assign off_s  = signed'(EP_W'({cfg.side_offset, FRAC_BITS'(0)}));

   always_comb begin
      ep_in = lavg_s - ravg_s;
      if (osign == 2'b01) begin
         ep_in = lavg_s - ravg_s + off_s;
      end else if (osign == 2'b10) begin
         ep_in = lavg_s - ravg_s - off_s;
      end
   end

   assign ed_in = ED_W'(ep_in) - ED_W'(prev_ff);

   // Two thirds of the integral, truncated toward zero, by reciprocal multiply.
   assign two_i = {integ_ff, 1'b0};
   assign mag   = two_i[INT_W] ? DIV3_IN_W'(-two_i) : DIV3_IN_W'(two_i);
   assign prod3 = mag * DIV3_RECIP;

   assign q_s       = qneg_ff ? -signed'(INT_W'(q_ff)) : signed'(INT_W'(q_ff));
   assign integ_sum = (INT_W + 1)'(q_s) + (INT_W + 1)'(ep_ff);
   always_comb begin
      if (integ_sum > 32767) begin
         integ_in = 16'sh7fff;
      end else if (integ_sum < -32768) begin
         integ_in = 16'sh8000;
      end else begin
         integ_in = integ_sum[INT_W-1:0];
      end
   end

   assign gp_s   = signed'({1'b0, cfg.gain_p});
   assign gi_s   = signed'({1'b0, cfg.gain_i});
   assign gd_s   = signed'({1'b0, cfg.gain_d});
   assign prod_p = gp_s * ep_ff;
   assign prod_d = gd_s * ed_ff;
   assign prod_i = gi_s * integ_ff;

   always_comb begin
      acc_in = acc_ff;
      if (cmd.integ) begin
         acc_in = ACC_W'(prod_p);
      end else if (cmd.muld) begin
         acc_in = acc_ff + ACC_W'(prod_d);
      end else if (cmd.muli) begin
         acc_in = acc_ff + ACC_W'(prod_i);
      end
   end

   // Scale back by the gain and error fractions, truncating toward zero.
   assign rounded = acc_ff + (acc_ff[ACC_W-1] ? ACC_W'((1 << SUM_SHIFT) - 1) : ACC_W'(0));
   assign shifted = rounded >>> SUM_SHIFT;
   always_comb begin
      if (shifted > 2047) begin
         err_in = 12'sh7ff;
      end else if (shifted < -2048) begin
         err_in = 12'sh800;
      end else begin
         err_in = shifted[ERR_W-1:0];
      end
   end

   assign base_s = signed'(DRV_W'(cfg.base_speed));
   assign err_w  = DRV_W'(err_in);
   assign rms    = base_s + err_w;
   assign lms    = base_s - err_w;

   always_comb begin
      ldrv_in = sat8(lms);
      rdrv_in = sat8(rms);
      head_in = HEAD_FORWARD;
      if (rms < 0) begin
         rdrv_in = sat8(-rms);
         head_in = HEAD_RIGHT;
      end else if (lms < 0) begin
         ldrv_in = sat8(-lms);
         head_in = HEAD_LEFT;
      end
   end

   assign stop = (lavg_ff == '0)
      || (({1'b0, lavg_ff} > MAX_AVG) && (ravg_ff == '0))
      || (({1'b0, ravg_ff} > MAX_AVG) && (favg_ff == '0))
      || ({1'b0, favg_ff} > MAX_AVG);

   always_comb begin
      fmode_in = fmode_ff;
      if (fmode_ff == MODE_CENTER && corner) begin
         fmode_in = lw_ff ? MODE_RIGHT : MODE_LEFT;
      end
   end

   always_comb begin
      out_in.left_drive    = ldrv_ff;
      out_in.right_drive   = rdrv_ff;
      out_in.heading       = stop ? HEAD_STOP : head_ff;
      out_in.left_wall     = lw_ff;
      out_in.right_wall    = rw_ff;
      out_in.front_wall    = fw_ff;
      out_in.mode_now      = fmode_in;
      out_in.control_error = err_ff;
   end

   // State that reset clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         lavg_ff      <= '0;
         ravg_ff      <= '0;
         favg_ff      <= '0;
         prev_ff      <= '0;
         integ_ff     <= '0;
         fmode_ff     <= MODE_CENTER;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            lavg_ff <= lavg_in;
            ravg_ff <= ravg_in;
            favg_ff <= favg_in;
         end
         if (cmd.err) begin
            prev_ff <= ep_in;
         end
         if (cmd.integ) begin
            integ_ff <= integ_in;
         end
         if (cmd.emit) begin
            fmode_ff     <= fmode_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lw_ff <= {1'b0, lavg_in} < side_lim;
         rw_ff <= {1'b0, ravg_in} < side_lim;
         fw_ff <= {1'b0, favg_in} < front_lim;
      end
      if (cmd.err) begin
         ep_ff   <= ep_in;
         ed_ff   <= ed_in;
         q_ff    <= prod3[DIV3_SHIFT+Q3_W-1:DIV3_SHIFT];
         qneg_ff <= two_i[INT_W];
      end
      acc_ff <= acc_in;
      if (cmd.fin) begin
         err_ff  <= err_in;
         ldrv_ff <= ldrv_in;
         rdrv_ff <= rdrv_in;
         head_ff <= head_in;
      end
      if (cmd.emit) begin
         out_ff <= out_in;
      end
   end

endmodule
